// ===== rtl/icl2_pkg.sv =====
// Shared types, codes and widths of the inclusive L2 directory controller.
`timescale 1ns / 1ps
package icl2_pkg;

  localparam int ActW   = 3;
  localparam int LineW  = 10;
  localparam int IdW    = 4;
  localparam int InsW   = 2;
  localparam int KindW  = 3;
  localparam int LstW   = 2;
  localparam int StallW = 2;

  localparam logic [ActW-1:0] ACT_READ    = 3'd0;
  localparam logic [ActW-1:0] ACT_READX   = 3'd1;
  localparam logic [ActW-1:0] ACT_REPLACE = 3'd2;
  localparam logic [ActW-1:0] ACT_INVACK  = 3'd3;
  localparam logic [ActW-1:0] ACT_MEMDATA = 3'd4;
  localparam logic [ActW-1:0] ACT_EVICT   = 3'd5;

  localparam logic [KindW-1:0] MK_STATUS = 3'd0;
  localparam logic [KindW-1:0] MK_MEMRD  = 3'd1;
  localparam logic [KindW-1:0] MK_DATA   = 3'd2;
  localparam logic [KindW-1:0] MK_UPD    = 3'd3;
  localparam logic [KindW-1:0] MK_INVAL  = 3'd4;
  localparam logic [KindW-1:0] MK_WRC    = 3'd5;

  localparam logic [LstW-1:0] LS_NP  = 2'd0;
  localparam logic [LstW-1:0] LS_INV = 2'd1;
  localparam logic [LstW-1:0] LS_I2M = 2'd2;
  localparam logic [LstW-1:0] LS_SH  = 2'd3;

  localparam logic [StallW-1:0] STL_NONE  = 2'd0;
  localparam logic [StallW-1:0] STL_POLL  = 2'd1;
  localparam logic [StallW-1:0] STL_EVENT = 2'd2;

  localparam logic [InsW-1:0] INS_OK    = 2'd0;
  localparam logic [InsW-1:0] INS_EVENT = 2'd2;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_REDUCE,
    CS_DECIDE,
    CS_PRE,
    CS_FAN,
    CS_POST,
    CS_STATUS
  } ctrl_state_e;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic reduce_step;
    logic decide;
    logic emit_pre;
    logic emit_fan;
    logic emit_post;
    logic emit_status;
  } icl2_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic needs_reduce;
    logic out_free;
    logic dec_pre;
    logic dec_fan;
    logic dec_post;
    logic sweep_nz;
    logic sweep_last;
    logic post_q;
  } icl2_status_t;

endpackage

// ===== rtl/icl2_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module icl2_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/icl2_ctrl.sv =====
// Controller state machine that sequences each directory item.
`timescale 1ns / 1ps
module icl2_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  icl2_pkg::icl2_status_t sts_i,
  output icl2_pkg::icl2_cmd_t    cmd_o
);
  import icl2_pkg::*;

  ctrl_state_e state_q, state_d;
  ctrl_state_e after_pre, after_fan;

  always_comb begin
    after_fan = sts_i.post_q ? CS_POST : CS_STATUS;
    after_pre = sts_i.sweep_nz ? CS_FAN : after_fan;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_CLEAR: begin
        if (sts_i.clear_done) state_d = CS_IDLE;
      end
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_REDUCE;
      end
      CS_REDUCE: begin
        if (!sts_i.needs_reduce) state_d = CS_DECIDE;
      end
      CS_DECIDE: begin
        if (sts_i.dec_pre) state_d = CS_PRE;
        else if (sts_i.dec_fan) state_d = CS_FAN;
        else if (sts_i.dec_post) state_d = CS_POST;
        else state_d = CS_STATUS;
      end
      CS_PRE: begin
        if (sts_i.out_free) state_d = after_pre;
      end
      CS_FAN: begin
        if (sts_i.out_free && sts_i.sweep_last) state_d = after_fan;
      end
      CS_POST: begin
        if (sts_i.out_free) state_d = CS_STATUS;
      end
      CS_STATUS: begin
        if (sts_i.out_free) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      CS_CLEAR:  cmd_o.clear_step = 1'b1;
      CS_IDLE:   cmd_o.capture = in_valid_i;
      CS_REDUCE: cmd_o.reduce_step = 1'b1;
      CS_DECIDE: cmd_o.decide = 1'b1;
      CS_PRE:    cmd_o.emit_pre = 1'b1;
      CS_FAN:    cmd_o.emit_fan = 1'b1;
      CS_POST:   cmd_o.emit_post = 1'b1;
      CS_STATUS: cmd_o.emit_status = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != CS_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/icl2_dp.sv =====
// Datapath: directory memories, protocol decision, sharer fan-out and output register.
`timescale 1ns / 1ps
module icl2_dp #(
  parameter int Lines   = 1024,
  parameter int Sharers = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  icl2_pkg::icl2_cmd_t           cmd_i,
  output icl2_pkg::icl2_status_t        sts_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic                          cfg_data_i,
  input  logic [icl2_pkg::ActW-1:0]     action_i,
  input  logic [icl2_pkg::LineW-1:0]    line_index_i,
  input  logic [icl2_pkg::IdW-1:0]      req_cache_i,
  input  logic [icl2_pkg::IdW-1:0]      source_id_i,
  input  logic                          thread_state_flag_i,
  input  logic                          miss_slot_free_i,
  input  logic                          memory_port_ready_i,
  input  logic [icl2_pkg::InsW-1:0]     insert_block_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [icl2_pkg::KindW-1:0]    message_kind_o,
  output logic [icl2_pkg::IdW-1:0]      destination_o,
  output logic [icl2_pkg::IdW-1:0]      on_behalf_of_o,
  output logic [icl2_pkg::LineW-1:0]    line_out_o,
  output logic [icl2_pkg::LstW-1:0]     new_state_o,
  output logic [icl2_pkg::StallW-1:0]   stall_kind_o,
  output logic                          illegal_o,
  output logic                          last_o
);
  import icl2_pkg::*;

  localparam int AddrW = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int SelW  = $clog2(Sharers);
  localparam int DirW  = LstW + Sharers;

  logic                incl_q, byp_q;
  logic [ActW-1:0]     act_q;
  logic [LineW-1:0]    line_q, idx_q, idx_d;
  logic [IdW-1:0]      req_q, src_q;
  logic                tflag_q, slot_q, port_q;
  logic [InsW-1:0]     ins_q;
  logic [AddrW-1:0]    clr_q;

  logic                dir_we;
  logic [AddrW-1:0]    dir_waddr, rd_addr;
  logic [DirW-1:0]     dir_wdata, dir_rdata;
  logic [IdW-1:0]      pend_rdata;

  logic [LstW-1:0]     cur;
  logic [Sharers-1:0]  old_mask, bit_req, bit_src;
  logic                tst, bad, pend_we;
  logic [StallW-1:0]   stall;
  logic [LstW-1:0]     nxt;
  logic [Sharers-1:0]  new_mask, fan_mask;
  logic                has_pre, has_post;
  logic [KindW-1:0]    pre_kind, fan_kind;
  logic [IdW-1:0]      pre_dst, pre_beh;

  logic [KindW-1:0]    pre_kind_q, fan_kind_q;
  logic [IdW-1:0]      pre_dst_q, pre_beh_q;
  logic                post_q;
  logic [LstW-1:0]     res_nxt_q;
  logic [StallW-1:0]   res_stall_q;
  logic                res_bad_q;
  logic [Sharers-1:0]  sweep_q, sweep_d, low;
  logic [SelW-1:0]     fan_sel;

  logic                out_free, load;
  logic                out_valid_q;
  logic [KindW-1:0]    kind_d, kind_q;
  logic [IdW-1:0]      dst_d, dst_q, beh_d, beh_q;
  logic [LstW-1:0]     onxt_d, onxt_q;
  logic [StallW-1:0]   ostall_d, ostall_q;
  logic                oill_d, oill_q, olast_d, olast_q;
  logic [LineW-1:0]    oline_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_q <= 1'b0;
      byp_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i) byp_q <= cfg_data_i;
      else incl_q <= cfg_data_i;
    end
  end

  assign sts_o.needs_reduce = ({22'd0, idx_q} >= 32'(Lines));
  assign idx_d = cmd_i.capture ? line_index_i : (idx_q - LineW'(Lines));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_i;
      line_q  <= line_index_i;
      req_q   <= req_cache_i;
      src_q   <= source_id_i;
      tflag_q <= thread_state_flag_i;
      slot_q  <= miss_slot_free_i;
      port_q  <= memory_port_ready_i;
      ins_q   <= insert_block_i;
    end
    if (cmd_i.capture || (cmd_i.reduce_step && sts_o.needs_reduce)) begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end
  assign sts_o.clear_done = (clr_q == AddrW'(Lines - 1));

  assign rd_addr   = AddrW'(idx_q);
  assign dir_we    = cmd_i.clear_step || cmd_i.decide;
  assign dir_waddr = cmd_i.clear_step ? clr_q : rd_addr;
  assign dir_wdata = cmd_i.clear_step ? '0 : {nxt, new_mask};

  icl2_ram #(.Width(DirW), .Depth(Lines)) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (rd_addr),
    .rdata_o (dir_rdata)
  );

  icl2_ram #(.Width(IdW), .Depth(Lines)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.decide && pend_we),
    .waddr_i (rd_addr),
    .wdata_i (req_q),
    .raddr_i (rd_addr),
    .rdata_o (pend_rdata)
  );

  assign cur      = dir_rdata[DirW-1 -: LstW];
  assign old_mask = dir_rdata[Sharers-1:0];
  assign bit_req  = ({28'd0, req_q} < 32'(Sharers)) ? (Sharers'(1) << req_q) : '0;
  assign bit_src  = ({28'd0, src_q} < 32'(Sharers)) ? (Sharers'(1) << src_q) : '0;
  assign tst      = byp_q && tflag_q && (act_q == ACT_READ || act_q == ACT_READX);

  always_comb begin
    bad      = 1'b0;
    stall    = STL_NONE;
    nxt      = cur;
    new_mask = old_mask;
    fan_mask = '0;
    fan_kind = MK_UPD;
    pend_we  = 1'b0;
    has_pre  = 1'b0;
    has_post = 1'b0;
    pre_kind = MK_DATA;
    pre_dst  = req_q;
    pre_beh  = req_q;
    if (act_q == ACT_REPLACE && cur != LS_SH) begin
      bad = incl_q;
    end else if (act_q > ACT_EVICT || act_q == ACT_INVACK) begin
      bad = 1'b1;
    end else if (cur == LS_NP || cur == LS_INV) begin
      if ((act_q == ACT_READ || act_q == ACT_READX) && !(cur == LS_INV && tst)) begin
        if (cur == LS_NP && ins_q != INS_OK) begin
          stall = (ins_q == INS_EVENT) ? STL_EVENT : STL_POLL;
        end
        if (!slot_q || !port_q) stall = STL_POLL;
        if (stall == STL_NONE) begin
          if (!tst) new_mask = old_mask | bit_req;
          pend_we  = 1'b1;
          has_pre  = 1'b1;
          pre_kind = MK_MEMRD;
          pre_dst  = '0;
          nxt      = LS_I2M;
        end
      end else if (!(act_q == ACT_EVICT && cur == LS_INV)) begin
        bad = 1'b1;
      end
    end else if (cur == LS_I2M) begin
      if (act_q == ACT_READ || act_q == ACT_READX) begin
        stall = STL_EVENT;
      end else if (act_q == ACT_MEMDATA) begin
        has_pre = 1'b1;
        pre_dst = pend_rdata;
        pre_beh = pend_rdata;
        nxt     = LS_SH;
      end else begin
        bad = 1'b1;
      end
    end else begin
      if (tst) begin
        has_pre = 1'b1;
      end else if (act_q == ACT_READ) begin
        new_mask = old_mask | bit_req;
        has_pre  = 1'b1;
      end else if (act_q == ACT_READX) begin
        fan_mask = old_mask;
        new_mask = old_mask | bit_req;
        has_post = 1'b1;
      end else if (act_q == ACT_REPLACE) begin
        if ((old_mask & bit_req) != '0) new_mask = old_mask & ~bit_src;
      end else if (act_q == ACT_EVICT) begin
        fan_mask = old_mask;
        fan_kind = MK_INVAL;
        new_mask = '0;
        nxt      = LS_INV;
      end else begin
        bad = 1'b1;
      end
    end
    if (bad || stall != STL_NONE) begin
      nxt      = cur;
      new_mask = old_mask;
      pend_we  = 1'b0;
      has_pre  = 1'b0;
      has_post = 1'b0;
      fan_mask = '0;
      stall    = bad ? STL_NONE : stall;
    end
  end

  assign sts_o.dec_pre  = has_pre;
  assign sts_o.dec_fan  = (fan_mask != '0);
  assign sts_o.dec_post = has_post;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      pre_kind_q  <= pre_kind;
      pre_dst_q   <= pre_dst;
      pre_beh_q   <= pre_beh;
      fan_kind_q  <= fan_kind;
      post_q      <= has_post;
      res_nxt_q   <= nxt;
      res_stall_q <= stall;
      res_bad_q   <= bad;
    end
  end

  assign low = sweep_q & (~sweep_q + 1'b1);
  always_comb begin
    fan_sel = '0;
    for (int i = 0; i < Sharers; i++) begin
      if (low[i]) fan_sel = fan_sel | SelW'(i);
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign load = out_free && (cmd_i.emit_pre || cmd_i.emit_fan || cmd_i.emit_post ||
                             cmd_i.emit_status);

  always_comb begin
    sweep_d = sweep_q;
    if (cmd_i.decide) sweep_d = fan_mask;
    else if (cmd_i.emit_fan && out_free) sweep_d = sweep_q & ~low;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else begin
      sweep_q <= sweep_d;
    end
  end

  assign sts_o.out_free   = out_free;
  assign sts_o.sweep_nz   = (sweep_q != '0);
  assign sts_o.sweep_last = ((sweep_q & ~low) == '0);
  assign sts_o.post_q     = post_q;

  always_comb begin
    kind_d   = MK_STATUS;
    dst_d    = '0;
    beh_d    = '0;
    onxt_d   = '0;
    ostall_d = STL_NONE;
    oill_d   = 1'b0;
    olast_d  = 1'b0;
    if (cmd_i.emit_pre) begin
      kind_d = pre_kind_q;
      dst_d  = pre_dst_q;
      beh_d  = pre_beh_q;
    end else if (cmd_i.emit_fan) begin
      kind_d = fan_kind_q;
      dst_d  = IdW'(fan_sel);
      beh_d  = req_q;
    end else if (cmd_i.emit_post) begin
      kind_d = MK_WRC;
      dst_d  = src_q;
      beh_d  = req_q;
    end else begin
      onxt_d   = res_nxt_q;
      ostall_d = res_stall_q;
      oill_d   = res_bad_q;
      olast_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      dst_q    <= dst_d;
      beh_q    <= beh_d;
      oline_q  <= line_q;
      onxt_q   <= onxt_d;
      ostall_q <= ostall_d;
      oill_q   <= oill_d;
      olast_q  <= olast_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign message_kind_o = kind_q;
  assign destination_o  = dst_q;
  assign on_behalf_of_o = beh_q;
  assign line_out_o     = oline_q;
  assign new_state_o    = onxt_q;
  assign stall_kind_o   = ostall_q;
  assign illegal_o      = oill_q;
  assign last_o         = olast_q;

`ifndef SYNTHESIS
  a_sweep_empty_at_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> sweep_q == '0)
    else $error("sharer sweep not drained before next decision");

  a_illegal_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cmd_i.emit_status && res_bad_q) |=> (stall_kind_o == STL_NONE && last_o))
    else $error("illegal status beat carries a stall kind");

  a_message_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !cmd_i.emit_status) |=> (!last_o && message_kind_o != MK_STATUS))
    else $error("message beat marked as last or as status");
`endif

endmodule

// ===== rtl/inclusive_l2_coherence_controller_unit.sv =====
// Top level of the inclusive write-through L2 directory controller.
`timescale 1ns / 1ps
// Usage:
// Each input beat is one protocol event (L1 read, read-exclusive, replace,
// inv ack, memory data or evict) for one directory line. The block answers
// with a run of output beats: an optional memory read or data response,
// one update or invalidate beat per sharer, an optional write complete, and
// a final status beat with last set that carries next state, stall kind and
// the illegal flag.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. Items are handled one at a time: in_stall_o stays high from
// acceptance until the status beat has entered the output register.
// An item runs through capture, the directory RAM read and the decision,
// then one step per output beat. A line index at or above Lines is first
// brought below Lines by repeated subtraction of Lines. The output register
// holds a beat while the receiver stalls and the sequencer waits; the next
// item may be accepted while the last status beat still waits to be taken.
// After reset the directory is cleared, one line per cycle, through all
// Lines lines; no item is accepted during that time. Configuration writes
// are taken at any time.
module inclusive_l2_coherence_controller_unit #(
  parameter int Lines   = 1024,
  parameter int Sharers = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [icl2_pkg::ActW-1:0]     action_i,
  input  logic [icl2_pkg::LineW-1:0]    line_index_i,
  input  logic [icl2_pkg::IdW-1:0]      req_cache_i,
  input  logic [icl2_pkg::IdW-1:0]      source_id_i,
  input  logic                          thread_state_flag_i,
  input  logic                          miss_slot_free_i,
  input  logic                          memory_port_ready_i,
  input  logic [icl2_pkg::InsW-1:0]     insert_block_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [icl2_pkg::KindW-1:0]    message_kind_o,
  output logic [icl2_pkg::IdW-1:0]      destination_o,
  output logic [icl2_pkg::IdW-1:0]      on_behalf_of_o,
  output logic [icl2_pkg::LineW-1:0]    line_out_o,
  output logic [icl2_pkg::LstW-1:0]     new_state_o,
  output logic [icl2_pkg::StallW-1:0]   stall_kind_o,
  output logic                          illegal_o,
  output logic                          last_o
);
  import icl2_pkg::*;

  icl2_cmd_t    cmd;
  icl2_status_t sts;

  icl2_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  icl2_dp #(.Lines(Lines), .Sharers(Sharers)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .action_i            (action_i),
    .line_index_i        (line_index_i),
    .req_cache_i         (req_cache_i),
    .source_id_i         (source_id_i),
    .thread_state_flag_i (thread_state_flag_i),
    .miss_slot_free_i    (miss_slot_free_i),
    .memory_port_ready_i (memory_port_ready_i),
    .insert_block_i      (insert_block_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .message_kind_o      (message_kind_o),
    .destination_o       (destination_o),
    .on_behalf_of_o      (on_behalf_of_o),
    .line_out_o          (line_out_o),
    .new_state_o         (new_state_o),
    .stall_kind_o        (stall_kind_o),
    .illegal_o           (illegal_o),
    .last_o              (last_o)
  );

endmodule
